// ----- sv/hwq_pkg.sv -----
// Shared types, request codes and controller/datapath command and status for the wait queue.
`default_nettype none

package hwq_pkg;

  localparam int REQ_W = 2;
  localparam int KEY_W = 32;
  localparam int TID_W = 5;

  localparam logic [REQ_W-1:0] REQ_ADD      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WAKE_ONE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WAKE_ALL = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD     = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] resource_key;
    logic [TID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0] woken_thread;
    logic             found;
    logic             last;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MOD,
    OP_HEAD,
    OP_ADD_HEAD,
    OP_ADD_START,
    OP_ADD_STEP,
    OP_ADD_TAIL,
    OP_WK_START,
    OP_WK_MISS,
    OP_WK_HIT,
    OP_WK_CLR,
    OP_WK_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_drop;
    logic req_add;
    logic req_all;
    logic clr_last;
    logic mod_last;
    logic head_ok;
    logic link_ok;
    logic key_match;
    logic miss_cont;
    logic hit_cont;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/hwq_ram.sv -----
// Generic single-write, single-read RAM with registered, write-first read data.
`default_nettype none

module hwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/hwq_ctrl.sv -----
// Controller state machine that sequences clearing, bucket hashing and chain walks.
`default_nettype none

module hwq_ctrl
  import hwq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_HCHK  = 4'd4;
  localparam logic [3:0] S_AWALK = 4'd5;
  localparam logic [3:0] S_WCMP  = 4'd6;
  localparam logic [3:0] S_WCLR  = 4'd7;
  localparam logic [3:0] S_WEND  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (!sts_i.in_drop) begin
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd_o.op = OP_MOD;
        if (sts_i.mod_last) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o.op = OP_HEAD;
        state_d  = S_HCHK;
      end
      S_HCHK: begin
        if (sts_i.req_add) begin
          if (sts_i.head_ok) begin
            cmd_o.op = OP_ADD_START;
            state_d  = S_AWALK;
          end else begin
            cmd_o.op = OP_ADD_HEAD;
            state_d  = S_IDLE;
          end
        end else if (sts_i.head_ok) begin
          cmd_o.op = OP_WK_START;
          state_d  = S_WCMP;
        end else begin
          state_d = S_WEND;
        end
      end
      S_AWALK: begin
        if (sts_i.link_ok) begin
          cmd_o.op = OP_ADD_STEP;
        end else begin
          cmd_o.op = OP_ADD_TAIL;
          state_d  = S_IDLE;
        end
      end
      S_WCMP: begin
        if (sts_i.key_match) begin
          cmd_o.op = OP_WK_HIT;
          state_d  = S_WCLR;
        end else begin
          cmd_o.op = OP_WK_MISS;
          if (!sts_i.miss_cont) begin
            state_d = S_WEND;
          end
        end
      end
      S_WCLR: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_WK_CLR;
          if (sts_i.req_all && sts_i.hit_cont) begin
            state_d = S_WCMP;
          end else begin
            state_d = S_WEND;
          end
        end
      end
      S_WEND: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_WK_END;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE) && (cmd_o.op == OP_LOAD || !in_valid_i))
    else $error("input taken outside idle");

  a_clear_leads_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) && sts_i.clr_last |=> (state_q == S_IDLE))
    else $error("clearing pass did not end in idle");

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_WK_CLR || cmd_o.op == OP_WK_END) |-> sts_i.out_free)
    else $error("result issued into occupied output register");

endmodule

`default_nettype wire

// ----- sv/hwq_dp.sv -----
// Datapath: key hashing, bucket/link/key tables, chain walk registers and output register.
`default_nettype none

module hwq_dp
  import hwq_pkg::*;
#(
  parameter int THREADS  = 32,
  parameter int BUCKETS  = 127,
  parameter int KEY_BITS = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire req_t    in_data_i,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output rsp_t         out_data_o,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t      sts_o
);

  localparam int TW    = $clog2(THREADS);
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW    = $clog2(THREADS + 1);
  localparam int NW    = $clog2(THREADS);
  localparam int KP    = KEY_BITS + (KEY_BITS % 2);
  localparam int MODN  = KP / 2;
  localparam int MCW   = $clog2(MODN);
  localparam int CLR_N = (BUCKETS > THREADS) ? BUCKETS : THREADS;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [BW+1:0] B1 = (BW+2)'(BUCKETS);
  localparam logic [BW+1:0] B2 = (BW+2)'(2 * BUCKETS);
  localparam logic [BW+1:0] B3 = (BW+2)'(3 * BUCKETS);

  function automatic logic tid_ok(input logic [TID_W-1:0] t);
    return (t != '0) && (int'(t) < THREADS);
  endfunction

  function automatic logic [TW-1:0] to_idx(input logic [TID_W-1:0] t);
    return TW'(t);
  endfunction

  logic [REQ_W-1:0]    req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TID_W-1:0]    tid_q;
  logic [KP-1:0]       ksh_q;
  logic [MCW-1:0]      mcnt_q;
  logic [BW-1:0]       rem_q;
  logic [TID_W-1:0]    cur_q, prev_q, succ_q, pend_q;
  logic                pend_valid_q;
  logic [SW-1:0]       steps_q;
  logic [NW-1:0]       n_q;
  logic [CW-1:0]       clr_q;
  rsp_t                out_q;
  logic                out_valid_q;

  logic [TID_W-1:0]    bh_rdata, nl_rdata;
  logic [KEY_BITS-1:0] wk_rdata;

  logic                bh_we, bh_re, nl_we, wk_we, tbl_re;
  logic [BW-1:0]       bh_waddr;
  logic [TID_W-1:0]    bh_wdata, nl_wdata;
  logic [TW-1:0]       nl_waddr, wk_waddr, tbl_raddr;
  logic [KEY_BITS-1:0] wk_wdata;

  logic [BW+1:0]       mod_t;
  logic [BW+1:0]       mod_r;
  logic                out_free;
  dp_op_e              op;

  assign op       = cmd_i.op;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mod_t = {rem_q, ksh_q[KP-1 -: 2]};
    if (mod_t >= B3) begin
      mod_r = mod_t - B3;
    end else if (mod_t >= B2) begin
      mod_r = mod_t - B2;
    end else if (mod_t >= B1) begin
      mod_r = mod_t - B1;
    end else begin
      mod_r = mod_t;
    end
  end

  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = rem_q;
    bh_wdata = '0;
    bh_re    = (op == OP_HEAD);
    nl_we    = 1'b0;
    nl_waddr = to_idx(cur_q);
    nl_wdata = '0;
    wk_we    = 1'b0;
    wk_waddr = to_idx(cur_q);
    wk_wdata = '0;
    tbl_re   = 1'b0;
    tbl_raddr = to_idx(nl_rdata);
    unique case (op)
      OP_CLEAR: begin
        bh_we    = int'(clr_q) < BUCKETS;
        bh_waddr = clr_q[BW-1:0];
        nl_we    = int'(clr_q) < THREADS;
        nl_waddr = clr_q[TW-1:0];
        wk_we    = int'(clr_q) < THREADS;
        wk_waddr = clr_q[TW-1:0];
      end
      OP_HEAD: begin
        nl_we    = (req_q == REQ_ADD);
        nl_waddr = to_idx(tid_q);
        wk_we    = (req_q == REQ_ADD);
        wk_waddr = to_idx(tid_q);
        wk_wdata = key_q;
      end
      OP_ADD_HEAD: begin
        bh_we    = 1'b1;
        bh_wdata = tid_q;
      end
      OP_ADD_START, OP_WK_START: begin
        tbl_re    = 1'b1;
        tbl_raddr = to_idx(bh_rdata);
      end
      OP_ADD_STEP, OP_WK_MISS: begin
        tbl_re = 1'b1;
      end
      OP_ADD_TAIL: begin
        nl_we    = 1'b1;
        nl_wdata = tid_q;
      end
      OP_WK_HIT: begin
        bh_we    = (prev_q == '0);
        bh_wdata = nl_rdata;
        nl_we    = (prev_q != '0);
        nl_waddr = to_idx(prev_q);
        nl_wdata = nl_rdata;
        wk_we    = 1'b1;
      end
      OP_WK_CLR: begin
        nl_we     = 1'b1;
        tbl_re    = 1'b1;
        tbl_raddr = to_idx(succ_q);
      end
      default: begin
      end
    endcase
  end

  hwq_ram #(.WIDTH(TID_W), .DEPTH(BUCKETS)) u_bucket_head (
    .clk_i   (clk_i),
    .we_i    (bh_we),
    .waddr_i (bh_waddr),
    .wdata_i (bh_wdata),
    .re_i    (bh_re),
    .raddr_i (rem_q),
    .rdata_o (bh_rdata)
  );

  hwq_ram #(.WIDTH(TID_W), .DEPTH(THREADS)) u_next_link (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (nl_rdata)
  );

  hwq_ram #(.WIDTH(KEY_BITS), .DEPTH(THREADS)) u_waiting_key (
    .clk_i   (clk_i),
    .we_i    (wk_we),
    .waddr_i (wk_waddr),
    .wdata_i (wk_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (wk_rdata)
  );

  always_ff @(posedge clk_i) begin
    unique case (op)
      OP_LOAD: begin
        req_q  <= in_data_i.req_type;
        key_q  <= KEY_BITS'(in_data_i.resource_key);
        tid_q  <= in_data_i.thread_id;
        ksh_q  <= KP'(KEY_BITS'(in_data_i.resource_key));
        mcnt_q <= MCW'(MODN - 1);
        rem_q  <= '0;
      end
      OP_MOD: begin
        ksh_q  <= {ksh_q[KP-3:0], 2'b00};
        mcnt_q <= mcnt_q - MCW'(1);
        rem_q  <= mod_r[BW-1:0];
      end
      OP_ADD_START: begin
        cur_q   <= bh_rdata;
        steps_q <= '0;
      end
      OP_ADD_STEP: begin
        cur_q   <= nl_rdata;
        steps_q <= steps_q + SW'(1);
      end
      OP_WK_START: begin
        cur_q   <= bh_rdata;
        prev_q  <= '0;
        steps_q <= '0;
        n_q     <= '0;
      end
      OP_WK_MISS: begin
        prev_q  <= cur_q;
        cur_q   <= nl_rdata;
        steps_q <= steps_q + SW'(1);
      end
      OP_WK_HIT: begin
        succ_q  <= nl_rdata;
        steps_q <= steps_q + SW'(1);
      end
      OP_WK_CLR: begin
        pend_q <= cur_q;
        cur_q  <= succ_q;
        n_q    <= n_q + NW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (op == OP_CLEAR) begin
        clr_q <= clr_q + CW'(1);
      end
      if (op == OP_WK_START) begin
        pend_valid_q <= 1'b0;
      end else if (op == OP_WK_CLR) begin
        pend_valid_q <= 1'b1;
      end else if (op == OP_WK_END || op == OP_LOAD) begin
        pend_valid_q <= 1'b0;
      end
      if ((op == OP_WK_CLR && pend_valid_q) || op == OP_WK_END) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_WK_CLR && pend_valid_q) begin
      out_q <= '{woken_thread: pend_q, found: 1'b1, last: 1'b0};
    end else if (op == OP_WK_END) begin
      if (pend_valid_q) begin
        out_q <= '{woken_thread: pend_q, found: 1'b1, last: 1'b1};
      end else begin
        out_q <= '{woken_thread: '0, found: 1'b0, last: 1'b1};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.in_drop   = (in_data_i.req_type == REQ_RSVD) ||
                           ((in_data_i.req_type == REQ_ADD) && !tid_ok(in_data_i.thread_id));
  assign sts_o.req_add   = (req_q == REQ_ADD);
  assign sts_o.req_all   = (req_q == REQ_WAKE_ALL);
  assign sts_o.clr_last  = (clr_q == CW'(CLR_N - 1));
  assign sts_o.mod_last  = (mcnt_q == '0);
  assign sts_o.head_ok   = tid_ok(bh_rdata);
  assign sts_o.link_ok   = tid_ok(nl_rdata) && (int'(steps_q) < THREADS);
  assign sts_o.key_match = (wk_rdata == key_q);
  assign sts_o.miss_cont = tid_ok(nl_rdata) && (int'(steps_q) + 1 < THREADS) &&
                           (int'(n_q) < THREADS - 1);
  assign sts_o.hit_cont  = tid_ok(succ_q) && (int'(steps_q) < THREADS) &&
                           (int'(n_q) + 1 < THREADS - 1);
  assign sts_o.out_free  = out_free;

  a_bucket_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_HEAD) |-> (int'(rem_q) < BUCKETS))
    else $error("bucket index out of range");

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_ADD_STEP || op == OP_WK_MISS || op == OP_WK_HIT) |-> (int'(steps_q) < THREADS))
    else $error("chain walk exceeded its bound");

  a_unlink_valid_tid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_WK_HIT) |-> tid_ok(cur_q))
    else $error("unlink of an invalid thread id");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_WK_END) |=> out_valid_q && out_q.last && !pend_valid_q)
    else $error("final result not marked last");

endmodule

`default_nettype wire

// ----- sv/hashed_wait_queue_engine.sv -----
// Top level of the hashed wait queue: controller and datapath.
`default_nettype none

// Hashed wait queue. A thread waits on a key in bucket (key mod BUCKETS), and each bucket
// holds a FIFO chain linked through a per-thread successor table. After reset the block
// clears its tables over max(BUCKETS, THREADS) addresses (127 by default) with in_ready_o low.
// A request is then accepted, its key is reduced to its bucket two key bits per cycle, the
// bucket head is read and the chain is walked; a wake-one unlinks the first matching thread,
// a wake-all each one (at most THREADS-1), and a wake then issues a final result. While a
// result waits for out_ready_i the wake walk stalls. The walk is set by the single read
// port of the link and key tables, one link per cycle while no result waits for out_ready_i.
// An add gives no result; a wake gives one result per unlinked thread, or a single not-found
// result, and the last one carries last. Adds with thread id 0 or THREADS and above, and the
// unused request type, are taken and dropped at once.
module hashed_wait_queue_engine
  import hwq_pkg::*;
#(
  parameter int THREADS  = 32,
  parameter int BUCKETS  = 127,
  parameter int KEY_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hwq_dp #(
    .THREADS  (THREADS),
    .BUCKETS  (BUCKETS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

// ----- sim/hashed_wait_queue_engine_test.sv -----
// Self-checking testbench for the hashed wait queue engine with a built-in chain predictor.
module hashed_wait_queue_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hwq_pkg::*;

  localparam int THREADS = 32;
  localparam int unsigned BUCKETS = 127;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  logic [TID_W-1:0] chain_head [BUCKETS];
  logic [TID_W-1:0] chain_next [THREADS];
  logic [KEY_W-1:0] chain_key [THREADS];
  rsp_t wake_expect [$];
  req_t req_backlog [$];

  bit gen_busy [THREADS];
  bit [KEY_W-1:0] gen_key [THREADS];
  bit [KEY_W-1:0] key_pool [4];

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 53;
  int fail_count = 0;
  int cycle_count = 0;

  hashed_wait_queue_engine #(
    .THREADS (THREADS),
    .BUCKETS (BUCKETS),
    .KEY_BITS(KEY_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (chain_head[i]) chain_head[i] = '0;
    foreach (chain_next[i]) begin
      chain_next[i] = '0;
      chain_key[i] = '0;
    end
  end

  function automatic bit tid_valid(logic [TID_W-1:0] t);
    return (t != '0) && (int'(t) < THREADS);
  endfunction

  function automatic void link_thread(logic [KEY_W-1:0] b, logic [KEY_W-1:0] key,
                                      logic [TID_W-1:0] tid);
    logic [TID_W-1:0] cur;
    int steps;
    chain_next[tid] = '0;
    chain_key[tid] = key;
    cur = chain_head[b];
    if (!tid_valid(cur)) begin
      chain_head[b] = tid;
    end else begin
      steps = 0;
      while (steps < THREADS && tid_valid(chain_next[cur])) begin
        cur = chain_next[cur];
        steps++;
      end
      chain_next[cur] = tid;
    end
  endfunction

  function automatic void unlink_matches(logic [KEY_W-1:0] b, logic [KEY_W-1:0] key, bit all);
    logic [TID_W-1:0] prev;
    logic [TID_W-1:0] cur;
    logic [TID_W-1:0] nxt;
    int steps;
    bit done;
    rsp_t hit;
    rsp_t hits [$];
    prev = '0;
    cur = chain_head[b];
    steps = 0;
    done = 1'b0;
    while (tid_valid(cur) && steps < THREADS && hits.size() < THREADS - 1 && !done) begin
      steps++;
      if (chain_key[cur] != key) begin
        prev = cur;
        cur = chain_next[cur];
      end else begin
        nxt = chain_next[cur];
        if (prev == '0) chain_head[b] = nxt;
        else chain_next[prev] = nxt;
        chain_next[cur] = '0;
        chain_key[cur] = '0;
        hit.woken_thread = cur;
        hit.found = 1'b1;
        hit.last = 1'b0;
        hits.push_back(hit);
        cur = nxt;
        done = !all;
      end
    end
    if (hits.size() == 0) begin
      hit.woken_thread = '0;
      hit.found = 1'b0;
      hit.last = 1'b1;
      hits.push_back(hit);
    end else begin
      hits[hits.size()-1].last = 1'b1;
    end
    foreach (hits[i]) wake_expect.push_back(hits[i]);
  endfunction

  function automatic void apply_request(req_t r);
    logic [KEY_W-1:0] b;
    b = r.resource_key % BUCKETS;
    case (r.req_type)
      REQ_ADD: begin
        if (tid_valid(r.thread_id)) link_thread(b, r.resource_key, r.thread_id);
      end
      REQ_WAKE_ONE: unlink_matches(b, r.resource_key, 1'b0);
      REQ_WAKE_ALL: unlink_matches(b, r.resource_key, 1'b1);
      default: ;
    endcase
  endfunction

  task automatic queue_request(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [TID_W-1:0] tid);
    req_t item;
    item.req_type = kind;
    item.resource_key = key;
    item.thread_id = tid;
    req_backlog.push_back(item);
    if (kind == REQ_ADD && tid != '0) begin
      gen_busy[tid] = 1'b1;
      gen_key[tid] = key;
    end
    if (kind == REQ_WAKE_ALL) begin
      foreach (gen_busy[i]) if (gen_key[i] == key) gen_busy[i] = 1'b0;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [TID_W-1:0] busy [$];
    int r;
    foreach (gen_busy[i]) if (gen_busy[i]) busy.push_back(TID_W'(i));
    r = $urandom_range(9);
    if (r < 6 && busy.size() != 0) return gen_key[busy[$urandom_range(busy.size() - 1)]];
    if (r < 9) return key_pool[$urandom_range(3)];
    return $urandom();
  endfunction

  task automatic gen_random(int target);
    int counted;
    int sel;
    logic [TID_W-1:0] spare [$];
    logic [TID_W-1:0] tid;
    logic [KEY_W-1:0] key;
    key_pool[0] = $urandom();
    key_pool[1] = key_pool[0] + BUCKETS;
    key_pool[2] = $urandom();
    key_pool[3] = key_pool[2] + BUCKETS * $urandom_range(1000, 2);
    counted = 0;
    while (counted < target) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        spare.delete();
        for (int t = 1; t < THREADS; t++) if (!gen_busy[t]) spare.push_back(TID_W'(t));
        if (spare.size() == 0) begin
          queue_request(REQ_WAKE_ALL, pick_key(), TID_W'($urandom_range(31)));
        end else begin
          tid = spare[$urandom_range(spare.size() - 1)];
          key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(3)] : $urandom();
          queue_request(REQ_ADD, key, tid);
        end
        counted++;
      end else if (sel < 65) begin
        queue_request(REQ_WAKE_ONE, pick_key(), TID_W'($urandom_range(31)));
        counted++;
      end else if (sel < 85) begin
        queue_request(REQ_WAKE_ALL, pick_key(), TID_W'($urandom_range(31)));
        counted++;
      end else if (sel < 92) begin
        queue_request(REQ_ADD, $urandom(), '0);
      end else begin
        queue_request(REQ_RSVD, $urandom(), TID_W'($urandom_range(31)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid || wake_expect.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) apply_request(in_data);
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (wake_expect.size() == 0) begin
          $error("unexpected item: woken_thread=%0d found=%0b last=%0b",
                 out_data.woken_thread, out_data.found, out_data.last);
          fail_count++;
        end else begin
          want = wake_expect.pop_front();
          if (out_data.woken_thread !== want.woken_thread) begin
            $error("woken_thread: expected %0d, actual %0d",
                   want.woken_thread, out_data.woken_thread);
            fail_count++;
          end
          if (out_data.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, out_data.found);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] burst_key;
    logic [KEY_W-1:0] loop_key;
    logic [TID_W-1:0] loop_tid;
    logic [TID_W-1:0] other_tid;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_request(REQ_WAKE_ONE, 32'h0, 5'd0);
    queue_request(REQ_WAKE_ALL, 32'hFFFF_FFFF, 5'd31);
    queue_request(REQ_ADD, 32'hFFFF_FFFF, 5'd31);
    queue_request(REQ_ADD, 32'h0, 5'd1);
    queue_request(REQ_ADD, 32'd127, 5'd2);
    queue_request(REQ_ADD, 32'h0, 5'd3);
    queue_request(REQ_ADD, 32'd5, 5'd0);
    queue_request(REQ_RSVD, 32'h0, 5'd1);
    queue_request(REQ_WAKE_ONE, 32'h0, 5'd0);
    queue_request(REQ_WAKE_ALL, 32'h0, 5'd0);
    queue_request(REQ_WAKE_ONE, 32'd127, 5'd0);
    queue_request(REQ_WAKE_ALL, 32'hFFFF_FFFF, 5'd0);
    queue_request(REQ_WAKE_ONE, 32'd254, 5'd0);
    queue_request(REQ_ADD, 32'hAAAA_AAAA, 5'd16);
    queue_request(REQ_ADD, 32'h5555_5555, 5'd15);
    queue_request(REQ_WAKE_ALL, 32'hAAAA_AAAA + 32'd127, 5'd0);
    queue_request(REQ_WAKE_ONE, 32'h5555_5555, 5'd0);
    queue_request(REQ_WAKE_ONE, 32'hAAAA_AAAA, 5'd0);
    queue_request(REQ_ADD, 32'd5, 5'd4);
    queue_request(REQ_ADD, 32'd132, 5'd5);
    queue_request(REQ_ADD, 32'd5, 5'd6);
    queue_request(REQ_WAKE_ALL, 32'd5, 5'd0);
    queue_request(REQ_WAKE_ONE, 32'd132, 5'd0);

    // fill one chain with every thread, then drain it in one wake-all
    burst_key = $urandom();
    for (int t = THREADS - 1; t >= 1; t--) queue_request(REQ_ADD, burst_key, TID_W'(t));
    queue_request(REQ_WAKE_ALL, burst_key, TID_W'($urandom_range(31)));

    gen_random(20);
    wait_drained();
    send_idle_pct = 53;
    recv_idle_pct = 19;
    gen_random(30);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(30);

    // add four threads that may already be queued, then build a self-looped chain
    for (int n = 0; n < 4; n++) begin
      queue_request(REQ_ADD, key_pool[$urandom_range(3)], TID_W'($urandom_range(31, 1)));
    end
    loop_key = $urandom() & 32'h7FFF_FFFF;
    loop_tid = TID_W'($urandom_range(31, 1));
    other_tid = (loop_tid == 5'd31) ? 5'd1 : loop_tid + 5'd1;
    queue_request(REQ_ADD, loop_key, loop_tid);
    queue_request(REQ_ADD, loop_key, loop_tid);
    queue_request(REQ_WAKE_ALL, loop_key + BUCKETS, 5'd0);
    queue_request(REQ_ADD, loop_key + BUCKETS, other_tid);
    queue_request(REQ_WAKE_ONE, loop_key, 5'd0);
    queue_request(REQ_WAKE_ALL, loop_key + BUCKETS, 5'd0);
    queue_request(REQ_WAKE_ALL, loop_key, 5'd0);
    for (int n = 0; n < 4; n++) queue_request(REQ_WAKE_ALL, key_pool[n], 5'd0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && wake_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
